FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: src/ham6_pkg.sv
// ----------------------------------------------------------------------------
// ham6_pkg
// widths, code values and distance helpers for the ham6 pixel encoder
// ----------------------------------------------------------------------------
package ham6_pkg;

    localparam int PaletteEntries = 16;
    localparam int EntriesPerWord = 4;
    localparam int PaletteWords   = PaletteEntries / EntriesPerWord;
    localparam int CompW          = 4;
    localparam int ColorW         = 3 * CompW;
    localparam int CodeW          = 6;
    localparam int WordW          = EntriesPerWord * ColorW;
    localparam int IndexW         = $clog2(PaletteWords);
    localparam int EntryIdxW      = $clog2(PaletteEntries);
    localparam int SqW            = 2 * CompW;
    localparam int DistW          = SqW + 2;

    typedef logic [CompW-1:0]     comp_t;
    typedef logic [ColorW-1:0]    color_t;
    typedef logic [CodeW-1:0]     code_t;
    typedef logic [DistW-1:0]     dist_t;
    typedef logic [EntryIdxW-1:0] entry_idx_t;

    // upper two code bits select the kind of code
    localparam logic [CodeW-CompW-1:0] MOD_PALETTE = 2'b00;
    localparam logic [CodeW-CompW-1:0] MOD_BLUE    = 2'b01;
    localparam logic [CodeW-CompW-1:0] MOD_RED     = 2'b10;
    localparam logic [CodeW-CompW-1:0] MOD_GREEN   = 2'b11;

    localparam code_t CODE_BLUE  = {MOD_BLUE, {CompW{1'b0}}};
    localparam code_t CODE_RED   = {MOD_RED, {CompW{1'b0}}};
    localparam code_t CODE_GREEN = {MOD_GREEN, {CompW{1'b0}}};

    function automatic comp_t abs_diff(comp_t a, comp_t b);
        return (a > b) ? comp_t'(a - b) : comp_t'(b - a);
    endfunction

    function automatic logic [SqW-1:0] sq_diff(comp_t a, comp_t b);
        logic [SqW-1:0] d;
        d = {{CompW{1'b0}}, abs_diff(a, b)};
        return d * d;
    endfunction

    function automatic dist_t color_dist(color_t x, color_t y);
        dist_t s;
        s = dist_t'(sq_diff(x[2*CompW +: CompW], y[2*CompW +: CompW]))
          + dist_t'(sq_diff(x[CompW +: CompW], y[CompW +: CompW]))
          + dist_t'(sq_diff(x[0 +: CompW], y[0 +: CompW]));
        return s;
    endfunction

endpackage

FILE: src/ham6_pixel_encoder_unit.sv
// ----------------------------------------------------------------------------
// ham6_pixel_encoder_unit
// hold-and-modify encoder: one 12-bit rgb pixel in, one 6-bit code and the
// displayed colour out
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with pixel_color and line_start
//   output channel: out_valid / out_stall with ham_code and shown_color
//   palette: wr_en, wr_index, wr_data write four 48-bit words of four
//   entries each; write only while no pixel is in flight
//   latency: two cycles from an accepted input beat to the output beat
//   when the output is free (input register, then result register)
//   throughput: one pixel per cycle; the sixteen palette distances and
//   the modify choice are evaluated in one pass between the two registers,
//   and the previous colour/code are updated as the result is registered
//   reset: palette, previous colour and previous code go to zero, both
//   channels empty
//   stall: a stalled output beat holds; one more pixel waits in the input
//   register, and in_stall rises only while both registers are full
// ----------------------------------------------------------------------------
module ham6_pixel_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ham6_pkg::IndexW-1:0]   wr_index,
    input  logic [ham6_pkg::WordW-1:0]    wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ham6_pkg::ColorW-1:0]   pixel_color,
    input  logic                          line_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ham6_pkg::CodeW-1:0]    ham_code,
    output logic [ham6_pkg::ColorW-1:0]   shown_color
);
    import ham6_pkg::*;

    localparam int L1 = PaletteEntries / 2;
    localparam int L2 = PaletteEntries / 4;
    localparam int L3 = PaletteEntries / 8;

    logic [WordW-1:0] palette_reg [PaletteWords];

    logic   in_valid_reg;
    color_t pix_reg;
    logic   ls_reg;

    logic   out_valid_reg;
    code_t  code_reg;
    color_t shown_reg;
    color_t prev_shown_reg;
    code_t  prev_code_reg;

    code_t  code_next;
    color_t shown_next;
    logic   advance;

    color_t     entry [PaletteEntries];
    dist_t      d0    [PaletteEntries];
    dist_t      d1 [L1];
    dist_t      d2 [L2];
    dist_t      d3 [L3];
    entry_idx_t i1 [L1];
    entry_idx_t i2 [L2];
    entry_idx_t i3 [L3];
    color_t     c1 [L1];
    color_t     c2 [L2];
    color_t     c3 [L3];
    dist_t      best_d;
    entry_idx_t best_idx;
    color_t     best_color;

    comp_t  cr, cg, cb, pr, pg, pb;
    comp_t  dr, dg, db, dmax;
    logic   red_win, blue_win;
    color_t mod_color;
    code_t  mod_code;
    dist_t  mod_d;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid   = out_valid_reg;
    assign ham_code    = code_reg;
    assign shown_color = shown_reg;

    // palette entries and their distances to the wanted colour
    for (genvar g = 0; g < PaletteEntries; g++)
    begin : g_entry
        assign entry[g] = palette_reg[g / EntriesPerWord][(g % EntriesPerWord) * ColorW +: ColorW];
        assign d0[g]    = color_dist(entry[g], pix_reg);
    end

    // nearest entry, ties keep the lower index
    always_comb
    begin
        for (int k = 0; k < L1; k++)
        begin
            if (d0[2*k+1] < d0[2*k])
            begin
                d1[k] = d0[2*k+1];
                i1[k] = entry_idx_t'(2*k+1);
                c1[k] = entry[2*k+1];
            end
            else
            begin
                d1[k] = d0[2*k];
                i1[k] = entry_idx_t'(2*k);
                c1[k] = entry[2*k];
            end
        end
        for (int k = 0; k < L2; k++)
        begin
            if (d1[2*k+1] < d1[2*k])
            begin
                d2[k] = d1[2*k+1];
                i2[k] = i1[2*k+1];
                c2[k] = c1[2*k+1];
            end
            else
            begin
                d2[k] = d1[2*k];
                i2[k] = i1[2*k];
                c2[k] = c1[2*k];
            end
        end
        for (int k = 0; k < L3; k++)
        begin
            if (d2[2*k+1] < d2[2*k])
            begin
                d3[k] = d2[2*k+1];
                i3[k] = i2[2*k+1];
                c3[k] = c2[2*k+1];
            end
            else
            begin
                d3[k] = d2[2*k];
                i3[k] = i2[2*k];
                c3[k] = c2[2*k];
            end
        end
        if (d3[1] < d3[0])
        begin
            best_d     = d3[1];
            best_idx   = i3[1];
            best_color = c3[1];
        end
        else
        begin
            best_d     = d3[0];
            best_idx   = i3[0];
            best_color = c3[0];
        end
    end

    // modify candidate: the component that differs most, bias green, red, blue
    always_comb
    begin
        cr = pix_reg[2*CompW +: CompW];
        cg = pix_reg[CompW +: CompW];
        cb = pix_reg[0 +: CompW];
        pr = prev_shown_reg[2*CompW +: CompW];
        pg = prev_shown_reg[CompW +: CompW];
        pb = prev_shown_reg[0 +: CompW];
        dr = abs_diff(cr, pr);
        dg = abs_diff(cg, pg);
        db = abs_diff(cb, pb);
        red_win  = dr > dg;
        dmax     = red_win ? dr : dg;
        blue_win = db > dmax;
        if (blue_win)
        begin
            mod_color = {pr, pg, cb};
            mod_code  = CODE_BLUE | code_t'(cb);
        end
        else if (red_win)
        begin
            mod_color = {cr, pg, pb};
            mod_code  = CODE_RED | code_t'(cr);
        end
        else
        begin
            mod_color = {pr, cg, pb};
            mod_code  = CODE_GREEN | code_t'(cg);
        end
        mod_d = color_dist(pix_reg, mod_color);
    end

    always_comb
    begin
        shown_next = pix_reg;
        if (!ls_reg && pix_reg == prev_shown_reg)
        begin
            code_next = prev_code_reg;
        end
        else if (!ls_reg && pg == cg && pb == cb)
        begin
            code_next = CODE_RED | code_t'(cr);
        end
        else if (!ls_reg && pb == cb && pr == cr)
        begin
            code_next = CODE_GREEN | code_t'(cg);
        end
        else if (!ls_reg && pr == cr && pg == cg)
        begin
            code_next = CODE_BLUE | code_t'(cb);
        end
        else if (best_d == '0)
        begin
            code_next = code_t'(best_idx);
        end
        else if (!ls_reg && mod_d < best_d)
        begin
            code_next  = mod_code;
            shown_next = mod_color;
        end
        else
        begin
            code_next  = code_t'(best_idx);
            shown_next = best_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PaletteWords; w++)
            begin
                palette_reg[w] <= '0;
            end
        end
        else if (wr_en)
        begin
            palette_reg[wr_index] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_shown_reg <= '0;
            prev_code_reg  <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                prev_shown_reg <= shown_next;
                prev_code_reg  <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pix_reg <= pixel_color;
            ls_reg  <= line_start;
        end
        if (advance && in_valid_reg)
        begin
            code_reg  <= code_next;
            shown_reg <= shown_next;
        end
    end

endmodule

FILE: src/ham6_checker.sv
// ----------------------------------------------------------------------------
// ham6_checker
// port-level checks for the ham6 pixel encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ham6_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ham6_pkg::CodeW-1:0]  ham_code,
    input logic [ham6_pkg::ColorW-1:0] shown_color
);
    import ham6_pkg::*;

    // stalled output beat stays and holds
    `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(ham_code) && $stable(shown_color), "output beat changed while stalled")

    // input backs up only behind a stalled output
    `ASSERT_NEVER(a_in_stall_src, in_stall && !(out_valid && out_stall), "input stalled with output free")

    // a new output beat comes from an earlier accepted input beat
    `ASSERT_CLK(a_out_source, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "output beat without input beat")

    // a modify code shows its value in the modified component
    `ASSERT_CLK(a_mod_value, out_valid |-> (ham_code[CodeW-1:CompW] == MOD_PALETTE) || (ham_code[CodeW-1:CompW] == MOD_RED && shown_color[2*CompW +: CompW] == ham_code[CompW-1:0]) || (ham_code[CodeW-1:CompW] == MOD_GREEN && shown_color[CompW +: CompW] == ham_code[CompW-1:0]) || (ham_code[CodeW-1:CompW] == MOD_BLUE && shown_color[0 +: CompW] == ham_code[CompW-1:0]), "modify value not shown")

endmodule

bind ham6_pixel_encoder_unit ham6_checker u_ham6_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ham_code    (ham_code),
    .shown_color (shown_color)
);

FILE: tb/ham6_pixel_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ham6_pixel_encoder_unit_test
// pixel beats with random gaps and random output stalls, checked in order
// against a scoreboard with its own copy of the palette and previous pixel;
// a directed run first, then random streams under several palettes, the
// all-zero and all-ones palettes among them
// ----------------------------------------------------------------------------
module ham6_pixel_encoder_unit_test;
    import ham6_pkg::*;

    localparam int DIST_START     = 1000;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 150;

    localparam logic [WordW-1:0] ALL_ONES_WORD = {WordW{1'b1}};
    localparam logic [WordW-1:0] SET_A_WORD_0  = 48'h0F0_F00_FFF_000;
    localparam logic [WordW-1:0] SET_A_WORD_1  = 48'h456_123_888_00F;
    localparam logic [WordW-1:0] SET_A_WORD_2  = 48'hC0C_444_FFF_7A3;
    localparam logic [WordW-1:0] SET_A_WORD_3  = 48'hFF0_0FF_E61_3C9;

    typedef enum int {PICK_RED, PICK_GREEN, PICK_BLUE} pick_t;

    typedef struct packed {
        code_t  code;
        color_t shown;
    } ham_result_t;

    class ham_code_scoreboard;
        logic [WordW-1:0] palette_word [PaletteWords];
        color_t           last_shown;
        code_t            last_code;
        ham_result_t      pending [$];
        int               mismatches;
        int               compared;
        int               line_starts;

        function new();
            foreach (palette_word[k])
                palette_word[k] = '0;
            last_shown  = '0;
            last_code   = '0;
            mismatches  = 0;
            compared    = 0;
            line_starts = 0;
        endfunction

        function color_t palette_entry(int i);
            return palette_word[i / EntriesPerWord][ColorW * (i % EntriesPerWord) +: ColorW];
        endfunction

        function int comp_gap(comp_t a, comp_t b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        function int rgb_distance(color_t a, color_t b);
            int dr, dg, db;
            dr = comp_gap(a[11:8], b[11:8]);
            dg = comp_gap(a[7:4], b[7:4]);
            db = comp_gap(a[3:0], b[3:0]);
            return dr * dr + dg * dg + db * db;
        endfunction

        function void note_pixel(color_t want, logic ls);
            int          best, bestd, d, m;
            bit          hit;
            pick_t       pick;
            comp_t       cr, cg, cb, pr, pg, pb, mr, mg, mb;
            code_t       code, mcode;
            color_t      shown, modified;
            ham_result_t r;
            cr = want[11:8];
            cg = want[7:4];
            cb = want[3:0];
            pr = last_shown[11:8];
            pg = last_shown[7:4];
            pb = last_shown[3:0];
            shown = want;
            hit = 1'b0;
            best = 0;
            bestd = DIST_START;
            if (ls)
                line_starts++;
            if (!ls && want == last_shown)
                code = last_code;
            else if (!ls && pg == cg && pb == cb)
                code = CODE_RED | code_t'(cr);
            else if (!ls && pb == cb && pr == cr)
                code = CODE_GREEN | code_t'(cg);
            else if (!ls && pr == cr && pg == cg)
                code = CODE_BLUE | code_t'(cb);
            else
            begin
                for (int i = 0; i < PaletteEntries && !hit; i++)
                begin
                    if (palette_entry(i) == want)
                    begin
                        best = i;
                        hit = 1'b1;
                    end
                    else
                    begin
                        d = rgb_distance(palette_entry(i), want);
                        if (d < bestd)
                        begin
                            bestd = d;
                            best = i;
                        end
                    end
                end
                code = code_t'(best);
                if (!hit)
                begin
                    shown = palette_entry(best);
                    if (!ls)
                    begin
                        // largest component step wins, ties favor green, then red
                        pick = PICK_GREEN;
                        m = comp_gap(cg, pg);
                        if (comp_gap(cr, pr) > m)
                        begin
                            pick = PICK_RED;
                            m = comp_gap(cr, pr);
                        end
                        if (comp_gap(cb, pb) > m)
                            pick = PICK_BLUE;
                        mr = pr;
                        mg = pg;
                        mb = pb;
                        case (pick)
                            PICK_RED:
                            begin
                                mr = cr;
                                mcode = CODE_RED | code_t'(cr);
                            end
                            PICK_GREEN:
                            begin
                                mg = cg;
                                mcode = CODE_GREEN | code_t'(cg);
                            end
                            default:
                            begin
                                mb = cb;
                                mcode = CODE_BLUE | code_t'(cb);
                            end
                        endcase
                        modified = {mr, mg, mb};
                        if (rgb_distance(modified, want) < bestd)
                        begin
                            code = mcode;
                            shown = modified;
                        end
                    end
                end
            end
            last_code = code;
            last_shown = shown;
            r.code = code;
            r.shown = shown;
            pending.push_back(r);
        endfunction

        function void check_pixel(code_t code, color_t shown);
            ham_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: ham_code %h shown_color %h", code, shown);
                mismatches++;
                return;
            end
            exp_r = pending.pop_front();
            compared++;
            if (code !== exp_r.code)
            begin
                $error("ham_code: expected %h, got %h", exp_r.code, code);
                mismatches++;
            end
            if (shown !== exp_r.shown)
            begin
                $error("shown_color: expected %h, got %h", exp_r.shown, shown);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                wr_en;
    logic [IndexW-1:0]   wr_index;
    logic [WordW-1:0]    wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [ColorW-1:0]   pixel_color;
    logic                line_start;
    logic                out_valid;
    logic                out_stall;
    logic [CodeW-1:0]    ham_code;
    logic [ColorW-1:0]   shown_color;

    ham_code_scoreboard tracker;
    bit                 idle_on;
    int                 stall_left;
    int                 quiet_cycles;
    int                 palette_settings;

    color_t directed_px [18] = '{12'hFFF, 12'hFFF, 12'h7FF, 12'h73F, 12'h735, 12'h888,
                                 12'h999, 12'h000, 12'h111, 12'h111, 12'h111, 12'hFF0,
                                 12'h00F, 12'hE62, 12'h0FF, 12'hA05, 12'h5A0, 12'hC0C};
    bit     directed_ls [18] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                                 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    ham6_pixel_encoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_color (pixel_color),
        .line_start  (line_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ham_code    (ham_code),
        .shown_color (shown_color)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // random output stalls
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_pixel(ham_code, shown_color);
            if (in_valid && !in_stall)
                tracker.note_pixel(pixel_color, line_start);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    task automatic send_pixel(color_t px, logic ls, int gap);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_color <= px;
        line_start  <= ls;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_palette(int k, logic [WordW-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= IndexW'(k);
        wr_data  <= data;
        tracker.palette_word[k] = data;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    function logic [WordW-1:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[WordW-1:0];
    endfunction

    task automatic load_palette(int phase);
        logic [ColorW-1:0] e;
        for (int k = 0; k < PaletteWords; k++)
        begin
            e = ColorW'($urandom);
            case (phase)
                0: write_palette(k, ALL_ONES_WORD);
                1: write_palette(k, '0);
                // repeated entries, lowest index must win
                2: write_palette(k, {EntriesPerWord{e}});
                default: write_palette(k, random_word());
            endcase
        end
        palette_settings++;
    endtask

    function color_t pick_pixel();
        int     r, k;
        color_t c;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 2);
        if (r < 15)
            c = tracker.last_shown;
        else if (r < 40)
        begin
            c = tracker.last_shown;
            c[4 * k +: 4] = comp_t'($urandom_range(0, 15));
        end
        else if (r < 55)
            c = tracker.palette_entry($urandom_range(0, PaletteEntries - 1));
        else if (r < 65)
        begin
            c = tracker.palette_entry($urandom_range(0, PaletteEntries - 1));
            c[4 * k +: 4] = c[4 * k +: 4] + ($urandom_range(0, 1) ? 4'd1 : 4'd15);
        end
        else
            c = color_t'($urandom);
        return c;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        in_valid     = 1'b0;
        pixel_color  = '0;
        line_start   = 1'b0;
        out_stall    = 1'b0;
        idle_on      = 1'b1;
        stall_left   = 0;
        quiet_cycles = 0;
        palette_settings = 1;
        tracker = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset palette: all entries black
        send_pixel(12'h000, 1'b0, pick_gap());
        send_pixel(12'hABC, 1'b1, pick_gap());
        drain();

        write_palette(0, SET_A_WORD_0);
        write_palette(1, SET_A_WORD_1);
        write_palette(2, SET_A_WORD_2);
        write_palette(3, SET_A_WORD_3);
        palette_settings++;
        foreach (directed_px[i])
            send_pixel(directed_px[i], directed_ls[i], pick_gap());
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_palette(phase);
            // every third phase runs back to back on both sides
            idle_on = (phase % 3 != 1);
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(pick_pixel(), ($urandom_range(0, 7) == 0), pick_gap());
            drain();
        end

        idle_on = 1'b0;
        repeat (4) @(posedge clk);
        $display("tb: %0d results compared (%0d line starts) over %0d palette settings",
                 tracker.compared, tracker.line_starts, palette_settings);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
